### rtl/core/dlr_pkg.sv
// Shared types and constants for the DDA line rasterizer.
// No dependencies; every other file but dlr_req_if imports this package.
`default_nettype none

package dlr_pkg;

    localparam int ADDR_W    = 34;
    localparam int COLOR_W   = 24;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 32;

    localparam logic [COLOR_W-1:0] COLOR_WHITE = 24'hFFFFFF;
    localparam logic [COLOR_W-1:0] COLOR_RED   = 24'hFF0000;

    localparam logic REQ_START = 1'b0;
    localparam logic REQ_TICK  = 1'b1;

    localparam logic [CFG_IDX_W-1:0] REG_WIN_WIDTH      = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_WIN_HEIGHT     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_BASE     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_LINE_STRIDE    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_BITS_PER_PIXEL = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_HIGHLIGHT      = 3'd5;

    typedef struct packed {
        logic [13:0] win_width;
        logic [13:0] win_height;
        logic [31:0] frame_base;
        logic [15:0] line_stride;
        logic [6:0]  bits_per_pixel;
        logic        highlight;
    } cfg_t;

    typedef struct packed {
        logic load;
        logic tick;
        logic div_step;
        logic div_last;
    } ctrl_cmd_t;

    typedef struct packed {
        logic tick_ready;
    } dp_status_t;

endpackage

`default_nettype wire

### rtl/core/dlr_req_if.sv
// Request channel: start/tick transactions with line endpoints.
// Depends on nothing.
`default_nettype none

interface dlr_req_if #(
    parameter int COORD_BITS = 16
);
    logic                         valid;
    logic                         ready;
    logic                         req_type;
    logic signed [COORD_BITS-1:0] start_x;
    logic signed [COORD_BITS-1:0] start_y;
    logic signed [COORD_BITS-1:0] end_x;
    logic signed [COORD_BITS-1:0] end_y;

    modport source (output valid, req_type, start_x, start_y, end_x, end_y, input ready);
    modport sink   (input valid, req_type, start_x, start_y, end_x, end_y, output ready);
endinterface

`default_nettype wire

### rtl/core/dlr_pix_if.sv
// Pixel result channel: one transaction per emitted pixel.
// Depends on dlr_pkg for address and color widths.
`default_nettype none

interface dlr_pix_if
    import dlr_pkg::*;
#(
    parameter int COORD_BITS = 16
);
    logic                         valid;
    logic                         ready;
    logic signed [COORD_BITS-1:0] pixel_x;
    logic signed [COORD_BITS-1:0] pixel_y;
    logic                         in_window;
    logic [ADDR_W-1:0]            pixel_address;
    logic [COLOR_W-1:0]           pixel_color;
    logic                         last_pixel;

    modport source (output valid, pixel_x, pixel_y, in_window, pixel_address, pixel_color,
                    last_pixel, input ready);
    modport sink   (input valid, pixel_x, pixel_y, in_window, pixel_address, pixel_color,
                    last_pixel, output ready);
endinterface

`default_nettype wire

### rtl/core/dlr_cfg_regs.sv
// Configuration register file for the rasterizer.
// Depends on dlr_pkg for cfg_t and register indexes.
`default_nettype none

module dlr_cfg_regs
    import dlr_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data,
    output cfg_t                       cfg
);

    cfg_t cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.win_width      <= 14'd640;
            cfg_reg.win_height     <= 14'd480;
            cfg_reg.frame_base     <= 32'd0;
            cfg_reg.line_stride    <= 16'd2560;
            cfg_reg.bits_per_pixel <= 7'd32;
            cfg_reg.highlight      <= 1'b0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_WIN_WIDTH:      cfg_reg.win_width      <= cfg_data[13:0];
                REG_WIN_HEIGHT:     cfg_reg.win_height     <= cfg_data[13:0];
                REG_FRAME_BASE:     cfg_reg.frame_base     <= cfg_data[31:0];
                REG_LINE_STRIDE:    cfg_reg.line_stride    <= cfg_data[15:0];
                REG_BITS_PER_PIXEL: cfg_reg.bits_per_pixel <= cfg_data[6:0];
                REG_HIGHLIGHT:      cfg_reg.highlight      <= cfg_data[0];
                default:            ;
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

`default_nettype wire

### rtl/core/dlr_ctrl.sv
// Controller FSM: request handshake and divider sequencing.
// Depends on dlr_pkg for command/status structs and request codes.
`default_nettype none

module dlr_ctrl
    import dlr_pkg::*;
#(
    parameter int FRAC_BITS = 16
)
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic req_valid,
    input  wire logic req_type,
    output logic      req_ready,
    input  dp_status_t status,
    output ctrl_cmd_t cmd
);

    localparam int CNT_W = $clog2(FRAC_BITS + 1);

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_DIV  = 1'b1;

    logic             state_reg, state_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             fire;

    always_comb
    begin
        state_next   = state_reg;
        cnt_next     = cnt_reg;
        req_ready    = 1'b0;
        cmd          = '0;
        fire         = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                req_ready = status.tick_ready;
                fire      = req_valid && req_ready;
                cmd.load  = fire && (req_type == REQ_START);
                cmd.tick  = fire && (req_type == REQ_TICK);
                if (cmd.load)
                begin
                    state_next = ST_DIV;
                    cnt_next   = '0;
                end
            end
            ST_DIV:
            begin
                cmd.div_step = 1'b1;
                cmd.div_last = (cnt_reg == CNT_W'(FRAC_BITS));
                cnt_next     = cnt_reg + 1'b1;
                if (cmd.div_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

endmodule

`default_nettype wire

### rtl/core/dlr_datapath.sv
// Datapath: endpoint load, two-lane restoring divider, DDA stepping and
// a three-stage pixel pipeline (truncate, multiply, address sum).
// Depends on dlr_pkg for cfg_t, command/status structs and constants.
`default_nettype none

module dlr_datapath
    import dlr_pkg::*;
#(
    parameter int COORD_BITS = 16,
    parameter int FRAC_BITS  = 16
)
(
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  ctrl_cmd_t                         cmd,
    output dp_status_t                        status,
    input  cfg_t                              cfg,
    input  wire logic signed [COORD_BITS-1:0] start_x,
    input  wire logic signed [COORD_BITS-1:0] start_y,
    input  wire logic signed [COORD_BITS-1:0] end_x,
    input  wire logic signed [COORD_BITS-1:0] end_y,
    output logic                              out_valid,
    input  wire logic                         out_ready,
    output logic signed [COORD_BITS-1:0]      pixel_x,
    output logic signed [COORD_BITS-1:0]      pixel_y,
    output logic                              in_window,
    output logic [ADDR_W-1:0]                 pixel_address,
    output logic [COLOR_W-1:0]                pixel_color,
    output logic                              last_pixel
);

    localparam int C     = COORD_BITS;
    localparam int F     = FRAC_BITS;
    localparam int DW    = C + 1;
    localparam int NW    = C + 1;
    localparam int QW    = F + 1;
    localparam int SW    = F + 2;
    localparam int PW    = C + F + 2;
    localparam int IW    = C + 2;
    localparam int PYW   = C + 16;
    localparam int PXW   = C + 4;
    localparam int SUMW  = ((PYW > 32) ? PYW : 32) + 2;

    // divider and line state
    logic [C-1:0]         div_reg;
    logic [NW-1:0]        rem_x_reg, rem_y_reg;
    logic [QW-1:0]        q_x_reg, q_y_reg;
    logic                 sign_x_reg, sign_y_reg;
    logic signed [SW-1:0] step_x_reg, step_y_reg;
    logic signed [PW-1:0] pos_x_reg, pos_y_reg;
    logic [NW-1:0]        pixels_left_reg;

    // pipeline stages
    logic                 s1_valid_reg, s2_valid_reg, out_valid_reg;
    logic [C-1:0]         s1_x_reg, s1_y_reg, s2_x_reg, s2_y_reg;
    logic                 s1_last_reg, s2_last_reg;
    logic                 s2_inwin_reg;
    logic [PYW-1:0]       s2_prod_y_reg;
    logic [PXW-1:0]       s2_prod_x_reg;
    logic [C-1:0]         out_x_reg, out_y_reg;
    logic                 out_inwin_reg, out_last_reg;
    logic [ADDR_W-1:0]    out_addr_reg;
    logic [COLOR_W-1:0]   out_color_reg;

    logic signed [DW-1:0] dx, dy;
    logic [DW-1:0]        ndx, ndy;
    logic [C-1:0]         mag_x, mag_y, steps;
    logic                 ge_x, ge_y;
    logic [NW-1:0]        diff_x, diff_y;
    logic [QW-1:0]        q_x_next, q_y_next;
    logic [SW-1:0]        qext_x, qext_y;
    logic                 emit;
    logic [IW-1:0]        trunc_x, trunc_y;
    logic                 out_adv, s2_free, s1_free;
    logic                 s1_inwin;
    logic [SUMW-1:0]      addr_sum;

    // endpoint deltas and step count
    always_comb
    begin
        dx    = {end_x[C-1], end_x} - {start_x[C-1], start_x};
        dy    = {end_y[C-1], end_y} - {start_y[C-1], start_y};
        ndx   = -dx;
        ndy   = -dy;
        mag_x = dx[DW-1] ? ndx[C-1:0] : dx[C-1:0];
        mag_y = dy[DW-1] ? ndy[C-1:0] : dy[C-1:0];
        steps = (mag_x > mag_y) ? mag_x : mag_y;
    end

    // one quotient bit per lane per cycle; zero steps gives zero increment
    always_comb
    begin
        ge_x     = (rem_x_reg >= {1'b0, div_reg}) && (div_reg != '0);
        ge_y     = (rem_y_reg >= {1'b0, div_reg}) && (div_reg != '0);
        diff_x   = ge_x ? (rem_x_reg - {1'b0, div_reg}) : rem_x_reg;
        diff_y   = ge_y ? (rem_y_reg - {1'b0, div_reg}) : rem_y_reg;
        q_x_next = {q_x_reg[QW-2:0], ge_x};
        q_y_next = {q_y_reg[QW-2:0], ge_y};
        qext_x   = {1'b0, q_x_next};
        qext_y   = {1'b0, q_y_next};
    end

    // truncate toward zero
    always_comb
    begin
        trunc_x = pos_x_reg[PW-1:F] + IW'(pos_x_reg[PW-1] && (|pos_x_reg[F-1:0]));
        trunc_y = pos_y_reg[PW-1:F] + IW'(pos_y_reg[PW-1] && (|pos_y_reg[F-1:0]));
    end

    assign out_adv           = !out_valid_reg || out_ready;
    assign s2_free           = !s2_valid_reg || out_adv;
    assign s1_free           = !s1_valid_reg || s2_free;
    assign status.tick_ready = s1_free;
    assign emit              = cmd.tick && (pixels_left_reg != '0);

    always_comb
    begin
        s1_inwin = !s1_x_reg[C-1] && !s1_y_reg[C-1]
                   && ({{14{1'b0}}, s1_x_reg} < {{C{1'b0}}, cfg.win_width})
                   && ({{14{1'b0}}, s1_y_reg} < {{C{1'b0}}, cfg.win_height});
        addr_sum = {{(SUMW-32){1'b0}}, cfg.frame_base}
                   + {{(SUMW-PYW){1'b0}}, s2_prod_y_reg}
                   + {{(SUMW-PXW){1'b0}}, s2_prod_x_reg};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pixels_left_reg <= '0;
            s1_valid_reg    <= 1'b0;
            s2_valid_reg    <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            if (cmd.load)
            begin
                pixels_left_reg <= {1'b0, steps} + 1'b1;
            end
            else if (emit)
            begin
                pixels_left_reg <= pixels_left_reg - 1'b1;
            end
            if (s1_free)
            begin
                s1_valid_reg <= emit;
            end
            if (s2_free)
            begin
                s2_valid_reg <= s1_valid_reg;
            end
            if (out_adv)
            begin
                out_valid_reg <= s2_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            div_reg    <= steps;
            rem_x_reg  <= {1'b0, mag_x};
            rem_y_reg  <= {1'b0, mag_y};
            sign_x_reg <= dx[DW-1];
            sign_y_reg <= dy[DW-1];
            pos_x_reg  <= {{2{start_x[C-1]}}, start_x, {F{1'b0}}};
            pos_y_reg  <= {{2{start_y[C-1]}}, start_y, {F{1'b0}}};
        end
        else if (emit)
        begin
            pos_x_reg <= pos_x_reg + {{(PW-SW){step_x_reg[SW-1]}}, step_x_reg};
            pos_y_reg <= pos_y_reg + {{(PW-SW){step_y_reg[SW-1]}}, step_y_reg};
        end
        if (cmd.div_step)
        begin
            rem_x_reg <= {diff_x[NW-2:0], 1'b0};
            rem_y_reg <= {diff_y[NW-2:0], 1'b0};
            q_x_reg   <= q_x_next;
            q_y_reg   <= q_y_next;
        end
        if (cmd.div_last)
        begin
            step_x_reg <= sign_x_reg ? -qext_x : qext_x;
            step_y_reg <= sign_y_reg ? -qext_y : qext_y;
        end
        if (s1_free && emit)
        begin
            s1_x_reg    <= trunc_x[C-1:0];
            s1_y_reg    <= trunc_y[C-1:0];
            s1_last_reg <= (pixels_left_reg == NW'(1));
        end
        if (s2_free)
        begin
            s2_x_reg      <= s1_x_reg;
            s2_y_reg      <= s1_y_reg;
            s2_last_reg   <= s1_last_reg;
            s2_inwin_reg  <= s1_inwin;
            s2_prod_y_reg <= s1_y_reg * cfg.line_stride;
            s2_prod_x_reg <= s1_x_reg * cfg.bits_per_pixel[6:3];
        end
        if (out_adv)
        begin
            out_x_reg     <= s2_x_reg;
            out_y_reg     <= s2_y_reg;
            out_inwin_reg <= s2_inwin_reg;
            out_last_reg  <= s2_last_reg;
            out_addr_reg  <= s2_inwin_reg ? addr_sum[ADDR_W-1:0] : '0;
            out_color_reg <= cfg.highlight ? COLOR_RED : COLOR_WHITE;
        end
    end

    assign out_valid     = out_valid_reg;
    assign pixel_x       = out_x_reg;
    assign pixel_y       = out_y_reg;
    assign in_window     = out_inwin_reg;
    assign pixel_address = out_addr_reg;
    assign pixel_color   = out_color_reg;
    assign last_pixel    = out_last_reg;

endmodule

`default_nettype wire

### rtl/core/dda_line_rasterizer_top.sv
// Top level of the DDA line rasterizer: config registers, controller, datapath.
// Depends on dlr_pkg, dlr_req_if, dlr_pix_if, dlr_cfg_regs, dlr_ctrl, dlr_datapath.
//
// A start transaction loads a line and occupies the block while it loads the
// endpoints and runs the bit-per-cycle divider that forms both increments.
// Tick transactions are then taken one per cycle unless the pipeline stalls;
// each emitted pixel passes through the registered truncate, multiply and
// address-sum stages in that order, and backpressure on the pixel channel
// stalls the pipeline, holding off further requests only once all three
// stages are full. A tick with no line loaded is consumed and produces no
// pixel. Clipped pixels carry address zero.
`default_nettype none

module dda_line_rasterizer_top
    import dlr_pkg::*;
#(
    parameter int COORD_BITS = 16,
    parameter int FRAC_BITS  = 16
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    dlr_req_if.sink                    req,
    dlr_pix_if.source                  pix,
    input  wire logic                  cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data
);

    cfg_t       cfg;
    ctrl_cmd_t  cmd;
    dp_status_t status;
    logic       req_ready;
    logic       out_valid;

    dlr_cfg_regs u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    dlr_ctrl #(
        .FRAC_BITS (FRAC_BITS)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req.valid),
        .req_type  (req.req_type),
        .req_ready (req_ready),
        .status    (status),
        .cmd       (cmd)
    );

    dlr_datapath #(
        .COORD_BITS (COORD_BITS),
        .FRAC_BITS  (FRAC_BITS)
    ) u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .status        (status),
        .cfg           (cfg),
        .start_x       (req.start_x),
        .start_y       (req.start_y),
        .end_x         (req.end_x),
        .end_y         (req.end_y),
        .out_valid     (out_valid),
        .out_ready     (pix.ready),
        .pixel_x       (pix.pixel_x),
        .pixel_y       (pix.pixel_y),
        .in_window     (pix.in_window),
        .pixel_address (pix.pixel_address),
        .pixel_color   (pix.pixel_color),
        .last_pixel    (pix.last_pixel)
    );

    assign req.ready = req_ready;
    assign pix.valid = out_valid;

endmodule

`default_nettype wire
